/* design/bte_pkg.sv */
// ----------------------------------------------------------------------------
// bte_pkg: shared types and constants of the boosted tree ensemble scorer
// Command codes, configuration indexes, memory record types and the walker state.
// ----------------------------------------------------------------------------
package bte_pkg;

  localparam int MAX_TREES  = 64;
  localparam int NODE_WORDS = 1024;
  localparam int FEATURES   = 64;
  localparam int WALK_LIMIT = 32;

  localparam int NODE_AW  = $clog2(NODE_WORDS);
  localparam int TREE_AW  = $clog2(MAX_TREES);
  localparam int FEAT_AW  = $clog2(FEATURES);
  localparam int STEP_W   = $clog2(WALK_LIMIT + 1);
  localparam int TCNT_W   = 7;
  localparam int SUM_W    = 23;
  localparam int IN_DW    = 120;
  localparam int OUT_DW   = 16;

  // command codes, carried in in_tuser
  localparam logic [1:0] CMD_NODE   = 2'd0;
  localparam logic [1:0] CMD_TREE   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // configuration register indexes
  localparam logic CFG_SCORE_BIAS = 1'b0;
  localparam logic CFG_TREE_COUNT = 1'b1;

  localparam logic signed [6:0]  LEAF_MARK = -7'sd1;
  localparam logic signed [15:0] Q15_MAX   = 16'sh7fff;
  localparam logic signed [15:0] Q15_MIN   = -16'sh8000;

  typedef struct packed {
    logic signed [6:0]  feat;
    logic signed [15:0] thr;
    logic signed [10:0] lft;
    logic signed [10:0] rgt;
    logic signed [15:0] val;
  } node_t;

  typedef struct packed {
    logic signed [10:0] root;
    logic [10:0]        size;
    logic [9:0]         base;
  } tree_rec_t;

  // store writes and scoring start, top level to walker
  typedef struct packed {
    logic               node_we;
    logic               tree_we;
    logic               feat_we;
    logic [9:0]         slot;
    node_t              node;
    tree_rec_t          tree;
    logic signed [15:0] sample;
    logic               start;
    logic signed [15:0] bias;
    logic [TCNT_W-1:0]  ntree;
  } bte_req_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_TREE      = 7'b0000010,
    S_TREE_WAIT = 7'b0000100,
    S_NODE      = 7'b0001000,
    S_NODE_WAIT = 7'b0010000,
    S_FEAT      = 7'b0100000,
    S_DONE      = 7'b1000000
  } walk_state_t;

endpackage

/* design/bte_walker.sv */
// ----------------------------------------------------------------------------
// bte_walker: node, tree and feature stores plus the tree walk sequencer
// One tree at a time, one node read per step, a single accumulator adder.
// ----------------------------------------------------------------------------
module bte_walker
  import bte_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  bte_req_t                req,
  output logic                    busy,
  output logic                    res_valid,
  input  logic                    res_ack,
  output logic signed [SUM_W-1:0] res_sum
);

  walk_state_t state_r, state_nxt;

  node_t     node_mem [NODE_WORDS];
  tree_rec_t tree_mem [MAX_TREES];
  logic signed [15:0] feat_mem [FEATURES];
  logic [FEATURES-1:0] feat_vld_r;

  node_t              node_q_r;
  tree_rec_t          tree_q_r;
  logic signed [15:0] feat_q_r;
  logic               fvld_q_r;

  logic [TCNT_W-1:0]       tree_i_r, tree_i_nxt;
  logic [TCNT_W-1:0]       ntree_r, ntree_nxt;
  logic signed [10:0]      idx_r, idx_nxt;
  logic [10:0]             size_r, size_nxt;
  logic [9:0]              base_r, base_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  logic [NODE_AW:0]        node_addr;
  logic                    idx_bad;
  logic signed [15:0]      feat_val;
  logic                    go_left;
  logic                    feat_bad;

  assign node_addr = {1'b0, base_r} + {1'b0, idx_r[9:0]};
  assign idx_bad   = idx_r[10] || ({1'b0, idx_r[9:0]} >= size_r) || node_addr[NODE_AW];
  assign feat_bad  = node_q_r.feat[6] || ({1'b0, node_q_r.feat[5:0]} >= 7'(FEATURES));
  assign feat_val  = fvld_q_r ? feat_q_r : 16'sd0;
  assign go_left   = feat_val <= node_q_r.thr;

  // stores
  always_ff @(posedge clk) begin
    if (req.node_we) node_mem[req.slot[NODE_AW-1:0]] <= req.node;
    node_q_r <= node_mem[node_addr[NODE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.tree_we) tree_mem[req.slot[TREE_AW-1:0]] <= req.tree;
    tree_q_r <= tree_mem[tree_i_r[TREE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.feat_we) feat_mem[req.slot[FEAT_AW-1:0]] <= req.sample;
    feat_q_r <= feat_mem[node_q_r.feat[FEAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_vld_r <= '0;
      fvld_q_r   <= 1'b0;
    end else begin
      if (req.feat_we) feat_vld_r[req.slot[FEAT_AW-1:0]] <= 1'b1;
      fvld_q_r <= feat_vld_r[node_q_r.feat[FEAT_AW-1:0]];
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    tree_i_nxt = tree_i_r;
    ntree_nxt  = ntree_r;
    idx_nxt    = idx_r;
    size_nxt   = size_r;
    base_nxt   = base_r;
    steps_nxt  = steps_r;
    sum_nxt    = sum_r;
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          sum_nxt    = SUM_W'(req.bias);
          ntree_nxt  = req.ntree;
          tree_i_nxt = '0;
          state_nxt  = S_TREE;
        end
      end
      S_TREE: begin
        state_nxt = (tree_i_r == ntree_r) ? S_DONE : S_TREE_WAIT;
      end
      S_TREE_WAIT: begin
        idx_nxt   = tree_q_r.root;
        size_nxt  = tree_q_r.size;
        base_nxt  = tree_q_r.base;
        steps_nxt = '0;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        if (idx_bad || steps_r == STEP_W'(WALK_LIMIT)) begin
          tree_i_nxt = tree_i_r + 1'b1;
          state_nxt  = S_TREE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_NODE_WAIT;
        end
      end
      S_NODE_WAIT: begin
        if (node_q_r.feat == LEAF_MARK) begin
          sum_nxt    = sum_r + SUM_W'(node_q_r.val);
          tree_i_nxt = tree_i_r + 1'b1;
          state_nxt  = S_TREE;
        end else if (feat_bad) begin
          tree_i_nxt = tree_i_r + 1'b1;
          state_nxt  = S_TREE;
        end else begin
          state_nxt = S_FEAT;
        end
      end
      S_FEAT: begin
        idx_nxt   = go_left ? node_q_r.lft : node_q_r.rgt;
        state_nxt = S_NODE;
      end
      S_DONE: begin
        if (res_ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tree_i_r <= tree_i_nxt;
    ntree_r  <= ntree_nxt;
    idx_r    <= idx_nxt;
    size_r   <= size_nxt;
    base_r   <= base_nxt;
    steps_r  <= steps_nxt;
    sum_r    <= sum_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_sum   = sum_r;

endmodule

/* design/boosted_tree_ensemble_scorer_unit.sv */
// ----------------------------------------------------------------------------
// boosted_tree_ensemble_scorer_unit: Q15 gradient boosted tree ensemble scorer
// Loads nodes, tree records and features; scores the ensemble on a last sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_* stream: in_tuser is the command (node write, tree record, feature
//   sample); in_tlast on a sample starts scoring. Load and sample transactions
//   that do not start scoring are accepted back to back.
//   A scoring transaction holds in_tready low while the sequencer walks the
//   trees one node memory read at a time: per tree it reads the tree record,
//   then per node visited it reads the node, then the feature, and steps to a
//   child; a leaf or a bad index ends the tree.
//   out_* stream: one transaction per scoring, score in out_tdata, saturation
//   flag in out_tuser. The result sits in an output register; loads keep being
//   accepted while it waits, and a further scoring finishes its walk but holds
//   its result until the receiver takes the previous one.
//   cfg_*: write base score (index 0) or tree count (index 1) while idle.
//   Reset clears the configuration and marks every feature as zero; node and
//   tree stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module boosted_tree_ensemble_scorer_unit
  import bte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // slot, feature_select, split_threshold,
                                        // left_next, right_next, leaf_score,
                                        // tree_root, tree_size, tree_base, sample
  input  logic [1:0]        in_tuser,   // command
  input  logic              in_tlast,   // last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // score
  output logic              out_tuser,  // clipped
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  logic signed [15:0] score_bias_r;
  logic [TCNT_W-1:0]  tree_count_r;
  logic               out_valid_r;
  logic [15:0]        out_score_r;
  logic               out_clip_r;

  bte_req_t                req;
  logic                    busy;
  logic                    res_valid;
  logic                    res_ack;
  logic signed [SUM_W-1:0] res_sum;
  logic                    in_fire;
  logic [1:0]              cmd;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = in_tuser;

  always_comb begin
    req.slot       = in_tdata[9:0];
    req.node.feat  = in_tdata[16:10];
    req.node.thr   = in_tdata[32:17];
    req.node.lft   = in_tdata[43:33];
    req.node.rgt   = in_tdata[54:44];
    req.node.val   = in_tdata[70:55];
    req.tree.root  = in_tdata[81:71];
    req.tree.size  = in_tdata[92:82];
    req.tree.base  = in_tdata[102:93];
    req.sample     = in_tdata[118:103];
    req.node_we    = in_fire && (cmd == CMD_NODE);
    req.tree_we    = in_fire && (cmd == CMD_TREE) && (in_tdata[9:TREE_AW] == '0);
    req.feat_we    = in_fire && (cmd == CMD_SAMPLE) && (in_tdata[9:FEAT_AW] == '0);
    req.start      = in_fire && (cmd == CMD_SAMPLE) && in_tlast;
    req.bias       = score_bias_r;
    req.ntree      = (tree_count_r > TCNT_W'(MAX_TREES)) ? TCNT_W'(MAX_TREES)
                                                          : tree_count_r;
  end

  bte_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res_sum   (res_sum)
  );

  assign res_ack = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_bias_r <= '0;
      tree_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCORE_BIAS: score_bias_r <= cfg_wdata;
        CFG_TREE_COUNT: tree_count_r <= cfg_wdata[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      if (res_sum > SUM_W'(Q15_MAX)) begin
        out_score_r <= Q15_MAX;
        out_clip_r  <= 1'b1;
      end else if (res_sum < SUM_W'(Q15_MIN)) begin
        out_score_r <= Q15_MIN;
        out_clip_r  <= 1'b1;
      end else begin
        out_score_r <= res_sum[15:0];
        out_clip_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_score_r;
  assign out_tuser  = out_clip_r;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the boosted tree ensemble scorer
// Loads node memory and tree table, streams feature samples and scores the
// ensemble under several base score / tree count settings. A scoreboard
// holds its own copy of the stores, walks the trees itself and compares
// every score transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
  import bte_pkg::*;

  localparam int IDLE_LIMIT   = 40000;
  localparam int DATA_BITS    = 119;
  // node entries loaded up front; every loaded and random tree record stays inside them
  localparam int FILLED_NODES = 256;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // bit offsets of the in_tdata fields
  localparam int F_SLOT = 0;
  localparam int F_FEAT = 10;
  localparam int F_THR  = 17;
  localparam int F_LFT  = 33;
  localparam int F_RGT  = 44;
  localparam int F_VAL  = 55;
  localparam int F_ROOT = 71;
  localparam int F_SIZE = 82;
  localparam int F_BASE = 93;
  localparam int F_SAMP = 103;

  typedef struct {
    logic [15:0] score;
    logic        clipped;
  } expected_score_t;

  class ensemble_scoreboard;
    node_t              node_mem[NODE_WORDS];
    tree_rec_t          tree_tab[MAX_TREES];
    logic signed [15:0] feat_mem[FEATURES];
    logic signed [15:0] score_bias;
    logic [TCNT_W-1:0]  tree_count;
    expected_score_t    pending_scores[$];
    int                 errors;
    int                 items;
    int                 checked;
    int                 clipped_seen;

    function new();
      foreach (feat_mem[i]) feat_mem[i] = '0;
      score_bias = '0;
      tree_count = '0;
      errors = 0;
      items = 0;
      checked = 0;
      clipped_seen = 0;
    endfunction

    function void set_reg(logic addr, logic [15:0] v);
      if (addr == CFG_SCORE_BIAS) begin
        score_bias = v;
      end else begin
        tree_count = v[TCNT_W-1:0];
      end
    endfunction

    // contribution of one tree; 0 on any bad node or feature index or an endless walk
    function int tree_contrib(int t);
      tree_rec_t rec;
      node_t     nd;
      int        idx;
      int        addr;
      int        f;
      rec = tree_tab[t];
      idx = $signed(rec.root);
      for (int walk_step = 0; walk_step < WALK_LIMIT; walk_step++) begin
        if (idx < 0 || idx >= int'(rec.size)) return 0;
        addr = int'(rec.base) + idx;
        if (addr >= NODE_WORDS) return 0;
        nd = node_mem[addr];
        f = $signed(nd.feat);
        if (f == LEAF_MARK) return $signed(nd.val);
        if (f < 0 || f >= FEATURES) return 0;
        idx = (feat_mem[f] <= $signed(nd.thr)) ? $signed(nd.lft) : $signed(nd.rgt);
      end
      return 0;
    endfunction

    function void ensemble_score();
      expected_score_t e;
      int              n;
      int              sum;
      n = (tree_count > MAX_TREES) ? MAX_TREES : int'(tree_count);
      sum = score_bias;
      for (int i = 0; i < n; i++) sum += tree_contrib(i);
      if (sum > Q15_MAX) begin
        e.score = Q15_MAX;
        e.clipped = 1'b1;
      end else if (sum < Q15_MIN) begin
        e.score = Q15_MIN;
        e.clipped = 1'b1;
      end else begin
        e.score = sum[15:0];
        e.clipped = 1'b0;
      end
      pending_scores.push_back(e);
    endfunction

    function void note_item(logic [1:0] cmd, logic [IN_DW-1:0] d, logic last);
      int slot;
      slot = d[F_SLOT +: 10];
      case (cmd)
        CMD_NODE: begin
          items++;
          node_mem[slot] = '{feat: d[F_FEAT +: 7], thr: d[F_THR +: 16],
                             lft: d[F_LFT +: 11], rgt: d[F_RGT +: 11],
                             val: d[F_VAL +: 16]};
        end
        CMD_TREE: begin
          items++;
          if (slot < MAX_TREES)
            tree_tab[slot] = '{root: d[F_ROOT +: 11], size: d[F_SIZE +: 11],
                               base: d[F_BASE +: 10]};
        end
        CMD_SAMPLE: begin
          items++;
          if (slot < FEATURES) feat_mem[slot] = d[F_SAMP +: 16];
          if (last) ensemble_score();
        end
        default: ;
      endcase
    endfunction

    function void check_score(logic [15:0] s, logic c);
      expected_score_t e;
      if (pending_scores.size() == 0) begin
        $error("score transaction with nothing expected: score %0d clipped %0d",
               $signed(s), c);
        errors++;
        return;
      end
      e = pending_scores.pop_front();
      checked++;
      if (e.clipped) clipped_seen++;
      if (s !== e.score) begin
        $error("score mismatch: expected %0d, actual %0d", $signed(e.score), $signed(s));
        errors++;
      end
      if (c !== e.clipped) begin
        $error("clipped mismatch: expected %0d, actual %0d", e.clipped, c);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // slot, feature_select, split_threshold, left_next,
                                 // right_next, leaf_score, tree_root, tree_size,
                                 // tree_base, sample
  logic [1:0]        in_tuser;   // command
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;  // score
  logic              out_tuser;  // clipped
  logic              cfg_we;
  logic              cfg_addr;
  logic [15:0]       cfg_wdata;

  ensemble_scoreboard sb;
  bit                 no_gaps;
  int                 idle_cycles;
  int                 ready_hold;
  int                 ready_roll;
  int                 settings;

  boosted_tree_ensemble_scorer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---- item builders: unused fields carry random bits -------------------

  function automatic logic [IN_DW-1:0] filler();
    logic [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    r[127:DATA_BITS] = '0;
    return r[IN_DW-1:0];
  endfunction

  function automatic int rand_q15();
    case ($urandom_range(0, 15))
      0: return 32'h7fff;
      1: return 32'h8000;
      2: return 0;
      3: return 32'hffff;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int rand_leaf();
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 4095)) - 2048;
    return rand_q15();
  endfunction

  function automatic logic [IN_DW-1:0] node_word(int slot, int feat, int thr,
                                                 int lft, int rgt, int val);
    logic [IN_DW-1:0] w;
    w = filler();
    w[F_SLOT +: 10] = slot[9:0];
    w[F_FEAT +: 7]  = feat[6:0];
    w[F_THR +: 16]  = thr[15:0];
    w[F_LFT +: 11]  = lft[10:0];
    w[F_RGT +: 11]  = rgt[10:0];
    w[F_VAL +: 16]  = val[15:0];
    return w;
  endfunction

  function automatic logic [IN_DW-1:0] tree_word(int slot, int root, int size, int base);
    logic [IN_DW-1:0] w;
    w = filler();
    w[F_SLOT +: 10] = slot[9:0];
    w[F_ROOT +: 11] = root[10:0];
    w[F_SIZE +: 11] = size[10:0];
    w[F_BASE +: 10] = base[9:0];
    return w;
  endfunction

  function automatic logic [IN_DW-1:0] sample_word(int slot, int value);
    logic [IN_DW-1:0] w;
    w = filler();
    w[F_SLOT +: 10] = slot[9:0];
    w[F_SAMP +: 16] = value[15:0];
    return w;
  endfunction

  // 16-node trees: locals 0..6 split into 2k+1 / 2k+2, the rest are leaves.
  // scramble picks arbitrary children in 0..15, which can close loops.
  function automatic logic [IN_DW-1:0] tree_node_word(int slot, bit scramble);
    int k;
    int l;
    int r;
    k = slot % 16;
    if (k < 7) begin
      l = scramble ? $urandom_range(0, 15) : 2 * k + 1;
      r = scramble ? $urandom_range(0, 15) : 2 * k + 2;
      return node_word(slot, $urandom_range(0, 15), rand_q15(), l, r,
                       $urandom_range(0, 65535));
    end
    return node_word(slot, -1, $urandom_range(0, 65535), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), rand_leaf());
  endfunction

  function automatic int sender_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---- drivers ------------------------------------------------------------

  task automatic send_item(input logic [1:0] cmd, input logic [IN_DW-1:0] data,
                           input logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_for_scores(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_scores.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(input int base, input int count);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SCORE_BIAS;
    cfg_wdata <= base[15:0];
    @(posedge clk);
    sb.set_reg(CFG_SCORE_BIAS, base[15:0]);
    cfg_addr  <= CFG_TREE_COUNT;
    cfg_wdata <= {9'd0, count[6:0]};
    @(posedge clk);
    sb.set_reg(CFG_TREE_COUNT, {9'd0, count[6:0]});
    cfg_we    <= 1'b0;
    settings++;
  endtask

  task automatic random_item(output bit counted);
    int               r;
    int               slot;
    int               size;
    int               nbase;
    logic [1:0]       cmd;
    logic [IN_DW-1:0] w;
    logic             lst;
    r = $urandom_range(0, 99);
    lst = ($urandom_range(0, 7) == 0);
    if (r < 55) begin
      cmd = CMD_SAMPLE;
      slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      w = sample_word(slot, rand_q15());
      lst = ($urandom_range(0, 99) < 18);
    end else if (r < 75) begin
      cmd = CMD_NODE;
      slot = $urandom_range(0, 1023);
      if ($urandom_range(0, 3) != 0)
        w = tree_node_word(slot, $urandom_range(0, 1));
      else
        w = node_word(slot, $urandom_range(0, 127), $urandom_range(0, 65535),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 65535));
    end else if (r < 93) begin
      cmd = CMD_TREE;
      slot = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
      if ($urandom_range(0, 9) < 7) begin
        size = $urandom_range(1, 16);
        w = tree_word(slot, $urandom_range(0, size - 1), size,
                      $urandom_range(0, FILLED_NODES - 16));
      end else begin
        nbase = $urandom_range(0, FILLED_NODES - 1);
        w = tree_word(slot, $urandom_range(0, 2047),
                      $urandom_range(0, FILLED_NODES - nbase), nbase);
      end
    end else begin
      cmd = CMD_UNUSED;
      w = filler();
    end
    send_item(cmd, w, lst);
    counted = (cmd != CMD_UNUSED);
  endtask

  // ---- receiver back-pressure ----------------------------------------------

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (ready_roll < 94) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(15, 60);
      end
    end
  end

  // ---- transaction monitor and watchdog ----------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_score(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------

  initial begin
    int  target;
    int  done_items;
    int  tc;
    int  base;
    bit  counted;
    sb = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_NODE;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_SCORE_BIAS;
    cfg_wdata  = '0;
    no_gaps    = 1'b0;
    idle_cycles = 0;
    ready_hold = 0;
    settings   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(0, 0);

    // fill the low node entries and every tree entry; the loaded and random
    // tree records stay inside the filled nodes, so no walk reads an unwritten one
    for (int t = 0; t < FILLED_NODES / 16; t++)
      for (int k = 0; k < 16; k++)
        send_item(CMD_NODE, tree_node_word(t * 16 + k, 1'b0), $urandom_range(0, 1));
    for (int t = 0; t < MAX_TREES; t++)
      send_item(CMD_TREE, tree_word(t, 0, 16, (t % (FILLED_NODES / 16)) * 16),
                $urandom_range(0, 1));

    // no trees: score is the base; stray last flags and dead slots
    send_item(CMD_SAMPLE, sample_word(5, 32'h7fff), 1'b0);
    send_item(CMD_UNUSED, filler(), 1'b1);
    send_item(CMD_NODE, node_word(1023, -1, 0, 0, 0, 32'h8000), 1'b1);
    send_item(CMD_TREE, tree_word(1023, -1024, 1024, 1023), 1'b1);
    send_item(CMD_SAMPLE, sample_word(1023, 32'h8000), 1'b1);
    wait_for_scores(8);

    // root on a leaf, negative root, root past size, address past memory
    write_config(32'h7fff, 2);
    send_item(CMD_TREE, tree_word(0, 15, 16, 0), 1'b0);
    send_item(CMD_NODE, node_word(15, -1, 0, 0, 0, 32'h7fff), 1'b0);
    send_item(CMD_TREE, tree_word(1, -1, 16, 16), 1'b0);
    send_item(CMD_SAMPLE, sample_word(0, 0), 1'b1);
    send_item(CMD_TREE, tree_word(1, 16, 16, 16), 1'b0);
    send_item(CMD_NODE, node_word(15, -1, 0, 0, 0, 1), 1'b0);
    send_item(CMD_TREE, tree_word(1, 7, 16, 1020), 1'b0);
    send_item(CMD_SAMPLE, sample_word(63, 32'hffff), 1'b1);
    wait_for_scores(8);

    // endless walk, bad feature number, low saturation
    write_config(32'h8000, 3);
    send_item(CMD_NODE, node_word(32, 0, 32'h7fff, 0, 0, 0), 1'b0);
    send_item(CMD_NODE, node_word(16, -64, 32'h8000, 1, 2, 0), 1'b0);
    send_item(CMD_TREE, tree_word(1, 0, 1024, 16), 1'b0);
    send_item(CMD_NODE, node_word(15, -1, 0, 0, 0, 32'h8000), 1'b0);
    send_item(CMD_SAMPLE, sample_word(1, 0), 1'b1);
    wait_for_scores(8);

    // tree count above the table size, child indexes at their extremes
    write_config(32'h1234, 127);
    send_item(CMD_NODE, node_word(48, 5, 0, -1024, 1023, 0), 1'b0);
    send_item(CMD_SAMPLE, sample_word(2, 0), 1'b1);
    send_item(CMD_TREE, tree_word(63, 0, 16, 48), 1'b0);
    send_item(CMD_SAMPLE, sample_word(5, 32'h8000), 1'b1);
    wait_for_scores(8);

    // random phases, each under its own setting
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin tc = 4;   base = 0;       end
        1: begin tc = 64;  base = rand_q15(); end
        2: begin tc = 0;   base = rand_q15(); end
        3: begin tc = 1;   base = 32'h7fff; end
        4: begin tc = 8;   base = 32'h8000; end
        5: begin tc = 127; base = rand_q15(); end
        default: begin tc = $urandom_range(1, 12); base = rand_q15(); end
      endcase
      no_gaps = (ph % 4 == 3);
      write_config(base, tc);
      target = 60;
      done_items = 0;
      while (done_items < target) begin
        random_item(counted);
        if (counted) done_items++;
      end
      wait_for_scores(8);
    end
    no_gaps = 1'b0;

    wait_for_scores(20);
    $display("covered %0d node/tree/sample transactions under %0d register settings",
             sb.items, settings);
    $display("compared %0d scores, %0d of them saturated", sb.checked, sb.clipped_seen);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
